// ===== hw/rtl/rtds_pkg.sv =====
`default_nettype none
package rtds_pkg;

    // Input and result field widths
    localparam int unsigned VALUE_W = 14;
    localparam int unsigned SYM_W   = 3;

    // Roman symbol codes
    localparam logic [SYM_W-1:0] SYM_I = 3'd0;
    localparam logic [SYM_W-1:0] SYM_X = 3'd2;
    localparam logic [SYM_W-1:0] SYM_C = 3'd4;
    localparam logic [SYM_W-1:0] SYM_M = 3'd6;

    // Digit extraction: thirteen compare-subtract steps
    localparam logic [3:0] C_STEP_LAST = 4'd12;
    localparam logic [3:0] C_STEP_HUND = 4'd5;
    localparam logic [3:0] C_STEP_TENS = 4'd9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DEC_THOU,
        DEC_HUND,
        DEC_TENS,
        DEC_UNIT
    } t_dec;

    // Symbol generator status toward the sequencer
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             has_sym;   // pos still inside this digit's pattern
        logic             dec_end;   // pos is the final symbol of this digit
        logic             last_sym;  // final symbol of the whole numeral
        logic             all_zero;  // numeral has no symbols
    } t_sym_info;

    // Trial weights: 16000,8000,4000,2000,1000, 800..100, 80..10
    function automatic logic [VALUE_W-1:0] f_weight(input logic [3:0] step);
        logic [VALUE_W-1:0] w;
        begin
            case (step)
                4'd0:    w = 14'd16000;
                4'd1:    w = 14'd8000;
                4'd2:    w = 14'd4000;
                4'd3:    w = 14'd2000;
                4'd4:    w = 14'd1000;
                4'd5:    w = 14'd800;
                4'd6:    w = 14'd400;
                4'd7:    w = 14'd200;
                4'd8:    w = 14'd100;
                4'd9:    w = 14'd80;
                4'd10:   w = 14'd40;
                4'd11:   w = 14'd20;
                4'd12:   w = 14'd10;
                default: w = '1;
            endcase
            return w;
        end
    endfunction

    // Number of symbols for a decimal digit
    function automatic logic [2:0] f_digit_len(input logic [3:0] d);
        logic [2:0] n;
        begin
            case (d)
                4'd1, 4'd5:       n = 3'd1;
                4'd2, 4'd4, 4'd6,
                4'd9:             n = 3'd2;
                4'd3, 4'd7:       n = 3'd3;
                4'd8:             n = 3'd4;
                default:          n = 3'd0;
            endcase
            return n;
        end
    endfunction

    // Step within the decade: 0 = one, 1 = five, 2 = ten
    function automatic logic [1:0] f_digit_step(input logic [3:0] d, input logic [1:0] pos);
        logic [1:0] s;
        begin
            case (d)
                4'd4:                   s = (pos == 2'd1) ? 2'd1 : 2'd0;
                4'd5, 4'd6, 4'd7, 4'd8: s = (pos == 2'd0) ? 2'd1 : 2'd0;
                4'd9:                   s = (pos == 2'd1) ? 2'd2 : 2'd0;
                default:                s = 2'd0;
            endcase
            return s;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rtds_in_if.sv =====
`default_nettype none
interface rtds_in_if;
    import rtds_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rtds_out_if.sv =====
`default_nettype none
interface rtds_out_if;
    import rtds_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             empty_res;

    modport source (output valid, output symbol, output last, output empty_res, input ready);
    modport sink   (input valid, input symbol, input last, input empty_res, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/decimal_to_roman_symbols.sv =====
// Channel  | Dir | Fields                         | Beat
// i_in     | in  | value[13:0]                    | one number
// o_out    | out | symbol[2:0], last, empty_res   | one Roman symbol
//
// One number is accepted, then gets one compare-subtract step per weight in
// the shared subtractor (binary-weighted digit extraction), then one beat
// per symbol, passing over each empty decade ahead of the final symbol (a
// single beat for an empty numeral).
// Synchronous active-low reset returns the sequencer to idle and drops o_out.valid.
// A stall on o_out holds the emit phase in place; i_in.ready is high only when idle.
`default_nettype none
module decimal_to_roman_symbols
    import rtds_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rtds_in_if.sink    i_in,
    rtds_out_if.source o_out
);

    t_state           r_state, n_state;
    logic [VALUE_W-1:0] r_rem;
    logic [3:0]       r_step;
    logic [4:0]       r_thou;
    logic [3:0]       r_hund;
    logic [3:0]       r_tens;
    t_dec             r_dec;
    logic [1:0]       r_pos;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_sym;
    logic             r_last;
    logic             r_empty;

    logic               in_take;
    logic               out_free;
    logic               sub_ge;
    logic [VALUE_W-1:0] sub_diff;
    t_sym_info          info;

    // Shared compare-subtract unit
    rtds_sub_unit u_sub (
        .i_rem    (r_rem),
        .i_weight (f_weight(r_step)),
        .o_ge     (sub_ge),
        .o_diff   (sub_diff)
    );

    // Symbol pattern lookup
    rtds_sym_gen u_sym (
        .i_thou (r_thou),
        .i_hund (r_hund),
        .i_tens (r_tens),
        .i_unit (r_rem[3:0]),
        .i_dec  (r_dec),
        .i_pos  (r_pos),
        .o_info (info)
    );

    assign out_free = !r_out_valid || o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_CONV;
            end
            S_CONV: begin
                if (r_step == C_STEP_LAST) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free && (info.all_zero || (info.has_sym && info.last_sym))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        in_take = 1'b0;
        case (r_state)
            S_IDLE:  in_take = i_in.valid;
            default: in_take = 1'b0;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Load the number, then extract digits one weight at a time
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rem  <= i_in.value;
            r_step <= '0;
            r_thou <= '0;
            r_hund <= '0;
            r_tens <= '0;
            r_dec  <= DEC_THOU;
            r_pos  <= '0;
        end else if (r_state == S_CONV) begin
            if (sub_ge) r_rem <= sub_diff;
            if (r_step < C_STEP_HUND) begin
                r_thou <= {r_thou[3:0], sub_ge};
            end else if (r_step < C_STEP_TENS) begin
                r_hund <= {r_hund[2:0], sub_ge};
            end else begin
                r_tens <= {r_tens[2:0], sub_ge};
            end
            r_step <= r_step + 4'd1;
        end else if (r_state == S_EMIT && out_free && !info.all_zero) begin
            // Advance through the pattern, skipping decades without symbols
            if (!info.has_sym || info.dec_end) begin
                r_dec <= t_dec'(r_dec + 2'd1);
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free && (info.all_zero || info.has_sym)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            if (info.all_zero) begin
                r_sym   <= SYM_I;
                r_last  <= 1'b1;
                r_empty <= 1'b1;
            end else if (info.has_sym) begin
                r_sym   <= info.sym;
                r_last  <= info.last_sym;
                r_empty <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.symbol    = r_sym;
    assign o_out.last      = r_last;
    assign o_out.empty_res = r_empty;

    // Beats are loaded only from the emit phase
    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("output beat loaded outside emit phase");

    // Extraction never runs past the final weight
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CONV |-> r_step <= C_STEP_LAST)
        else $error("digit extraction step out of range");

    // An empty numeral is a single closing beat
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_empty |-> r_last && r_sym == SYM_I)
        else $error("empty beat without last flag");

    // Units remainder, hundreds and tens are decimal digits once emission starts
    a_unit_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_rem < VALUE_W'(10) && r_hund <= 4'd9 && r_tens <= 4'd9)
        else $error("digit extraction left a non-decimal digit");

endmodule
`default_nettype wire

// ===== hw/rtl/rtds_sub_unit.sv =====
`default_nettype none
module rtds_sub_unit
    import rtds_pkg::*;
(
    input  wire logic [VALUE_W-1:0] i_rem,
    input  wire logic [VALUE_W-1:0] i_weight,
    output logic                    o_ge,
    output logic [VALUE_W-1:0]      o_diff
);

    // Compare and subtract the trial weight
    always_comb begin
        o_ge   = (i_rem >= i_weight);
        o_diff = i_rem - i_weight;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rtds_sym_gen.sv =====
`default_nettype none
module rtds_sym_gen
    import rtds_pkg::*;
(
    input  wire logic [4:0] i_thou,
    input  wire logic [3:0] i_hund,
    input  wire logic [3:0] i_tens,
    input  wire logic [3:0] i_unit,
    input  wire t_dec       i_dec,
    input  wire logic [1:0] i_pos,
    output t_sym_info       o_info
);

    logic [3:0] thou_mod;
    logic [2:0] len_thou;
    logic [2:0] len_hund;
    logic [2:0] len_tens;
    logic [2:0] len_unit;
    logic [2:0] len_cur;
    logic       later_zero;
    logic [3:0] dig_cur;
    logic [SYM_W-1:0] base;

    // Fold the thousands quotient into one digit; only 1 to 3 give symbols
    always_comb begin
        thou_mod = (i_thou >= 5'd10) ? 4'(i_thou - 5'd10) : i_thou[3:0];
        len_thou = (thou_mod >= 4'd1 && thou_mod <= 4'd3) ? thou_mod[2:0] : 3'd0;
        len_hund = f_digit_len(i_hund);
        len_tens = f_digit_len(i_tens);
        len_unit = f_digit_len(i_unit);
    end

    // Select the active decade
    always_comb begin
        case (i_dec)
            DEC_THOU: begin
                len_cur    = len_thou;
                later_zero = (len_hund == 3'd0) && (len_tens == 3'd0) && (len_unit == 3'd0);
                dig_cur    = thou_mod;
                base       = SYM_C;
            end
            DEC_HUND: begin
                len_cur    = len_hund;
                later_zero = (len_tens == 3'd0) && (len_unit == 3'd0);
                dig_cur    = i_hund;
                base       = SYM_C;
            end
            DEC_TENS: begin
                len_cur    = len_tens;
                later_zero = (len_unit == 3'd0);
                dig_cur    = i_tens;
                base       = SYM_X;
            end
            default: begin
                len_cur    = len_unit;
                later_zero = 1'b1;
                dig_cur    = i_unit;
                base       = SYM_I;
            end
        endcase
    end

    // Build the symbol and end flags
    always_comb begin
        o_info.has_sym  = ({1'b0, i_pos} < len_cur);
        o_info.dec_end  = ({1'b0, i_pos} == (len_cur - 3'd1));
        o_info.last_sym = o_info.dec_end && later_zero;
        o_info.all_zero = (len_thou == 3'd0) && (len_hund == 3'd0) &&
                          (len_tens == 3'd0) && (len_unit == 3'd0);
        if (i_dec == DEC_THOU) begin
            o_info.sym = SYM_M;
        end else begin
            o_info.sym = base + {1'b0, f_digit_step(dig_cur, i_pos)};
        end
    end

endmodule
`default_nettype wire
